// ----- src/fpm_pkg.sv -----
// ----------------------------------------------------------------------------
// fpm_pkg: shared types and constants for the single-precision multiplier
// carries the binary32 field constants and the stage-to-stage record
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW  = 24;
  localparam int unsigned ProdW = 48;
  localparam int unsigned XW    = 11;   // signed working exponent
  localparam int unsigned Bias  = 127;
  localparam int unsigned LzW   = 5;

  localparam logic [WordW-1:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [WordW-1:0] QuietBit   = 32'h0040_0000;
  localparam logic [ExpW-1:0]  ExpMax     = 8'hFF;

  // special-case outcome decided in the first stage
  typedef struct packed {
    logic             special;
    logic [WordW-1:0] word;
  } spec_t;

  // count leading zeros of a 24-bit significand (frac only, bit 23 clear)
  function automatic logic [LzW-1:0] lzc24(input logic [SigW-1:0] m);
    logic [LzW-1:0] n;
    logic           found;
    n = '0;
    found = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        n = LzW'(SigW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

// ----- src/fpm_round.sv -----
// ----------------------------------------------------------------------------
// fpm_round: normalize, denormalize and round a 48-bit significand product
// two register stages: shift with sticky, then round and pack
// ----------------------------------------------------------------------------
module fpm_round
  import fpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_sign,
  input  logic signed [XW-1:0]   in_exp,
  input  logic [ProdW-1:0]       in_prod,
  input  spec_t                  in_spec,
  output logic                   out_valid,
  output logic [WordW-1:0]       out_word
);

  logic                 norm_hi;
  logic signed [XW-1:0] exp_n;
  logic [ProdW-1:0]     p_n;
  logic [6:0]           sh;
  logic [ProdW-1:0]     p_sh;
  logic                 sticky;
  logic                 ovf;

  always_comb begin
    norm_hi = in_prod[ProdW-1];
    exp_n   = norm_hi ? in_exp + XW'(1) : in_exp;
    p_n     = norm_hi ? in_prod : {in_prod[ProdW-2:0], 1'b0};
    ovf     = exp_n >= XW'(255);
    if (exp_n <= 0) begin
      sh = (XW'(1) - exp_n > XW'(63)) ? 7'd63 : 7'(XW'(1) - exp_n);
    end else begin
      sh = '0;
    end
    if (sh >= 7'(ProdW)) begin
      p_sh   = '0;
      sticky = |p_n;
    end else begin
      p_sh   = p_n >> sh;
      sticky = |(p_n & ((ProdW'(1) << sh) - ProdW'(1)));
    end
  end

  // stage r1
  logic                 r1_valid;
  logic                 r1_sign;
  logic                 r1_ovf;
  logic                 r1_sub;
  logic [ExpW-1:0]      r1_exp;
  logic [ProdW-1:0]     r1_p;
  spec_t                r1_spec;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else begin
      r1_valid <= in_valid;
    end
    r1_sign <= in_sign;
    r1_ovf  <= ovf;
    r1_sub  <= exp_n <= 0;
    r1_exp  <= ExpW'(exp_n - XW'(1));
    r1_p    <= {p_sh[ProdW-1:1], p_sh[0] | sticky};
    r1_spec <= in_spec;
  end

  logic [SigW:0]      mant;
  logic [SigW-1:0]    rem;
  logic [WordW-2:0]   v;
  logic [WordW-1:0]   word_next;

  always_comb begin
    rem  = r1_p[SigW-1:0];
    mant = {1'b0, r1_p[ProdW-1:SigW]};
    if (rem > 24'h80_0000 || (rem == 24'h80_0000 && mant[0])) begin
      mant = mant + 1'b1;
    end
    if (r1_sub) begin
      v = 31'(mant);
    end else begin
      v = {r1_exp, 23'd0} + 31'(mant);
    end
    if (v >= 31'h7F80_0000 || r1_ovf) begin
      v = 31'h7F80_0000;
    end
    word_next = r1_spec.special ? r1_spec.word : {r1_sign, v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= r1_valid;
    end
    out_word <= word_next;
  end

endmodule

// ----- src/fp32_multiplier.sv -----
// ----------------------------------------------------------------------------
// fp32_multiplier: IEEE 754 binary32 multiplier, round to nearest even
// four-stage pipeline: unpack, multiply, normalize, round
// ----------------------------------------------------------------------------
// channel  | handshake     | payload
// request  | start / busy  | operand_a, operand_b
// result   | done (strobe) | product
//
// an accepted request passes the s1, s2 and r1 registers and the output register to its done strobe
// one request may enter every cycle; busy is held low, the pipe never stalls
// the limit per stage is the 24x24 significand multiplier in stage two
// rst clears only the valid bits; data registers run free
// the receiver cannot hold off a result, so none needs to wait
module fp32_multiplier
  import fpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WordW-1:0] operand_a,
  input  logic [WordW-1:0] operand_b,
  output logic             done,
  output logic [WordW-1:0] product
);

  assign busy = 1'b0;

  // stage 1: classify and normalize subnormal significands
  logic [ExpW-1:0]  ea, eb;
  logic [FracW-1:0] fa, fb;
  logic             a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic             sgn;
  spec_t            spec;
  logic [LzW-1:0]   lza, lzb;
  logic [SigW-1:0]  ma, mb;
  logic signed [XW-1:0] xa, xb;

  always_comb begin
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    fa = operand_a[22:0];
    fb = operand_b[22:0];
    sgn = operand_a[31] ^ operand_b[31];
    a_nan = (ea == ExpMax) && (fa != '0);
    b_nan = (eb == ExpMax) && (fb != '0);
    a_inf = (ea == ExpMax) && (fa == '0);
    b_inf = (eb == ExpMax) && (fb == '0);
    a_zero = operand_a[30:0] == '0;
    b_zero = operand_b[30:0] == '0;
    spec.special = 1'b1;
    if (a_nan) begin
      spec.word = operand_a | QuietBit;
    end else if (b_nan) begin
      spec.word = operand_b | QuietBit;
    end else if (a_inf || b_inf) begin
      spec.word = (a_zero || b_zero) ? DefaultNan : {sgn, ExpMax, 23'd0};
    end else if (a_zero || b_zero) begin
      spec.word = {sgn, 31'd0};
    end else begin
      spec.special = 1'b0;
      spec.word    = '0;
    end
    lza = lzc24({1'b0, fa});
    lzb = lzc24({1'b0, fb});
    if (ea == '0) begin
      ma = {1'b0, fa} << lza;
      xa = XW'(1) - XW'(lza) - XW'(Bias);
    end else begin
      ma = {1'b1, fa};
      xa = XW'(ea) - XW'(Bias);
    end
    if (eb == '0) begin
      mb = {1'b0, fb} << lzb;
      xb = XW'(1) - XW'(lzb) - XW'(Bias);
    end else begin
      mb = {1'b1, fb};
      xb = XW'(eb) - XW'(Bias);
    end
  end

  logic                 s1_valid, s1_sign;
  logic [SigW-1:0]      s1_ma, s1_mb;
  logic signed [XW-1:0] s1_exp;
  spec_t                s1_spec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_sign <= sgn;
    s1_ma   <= ma;
    s1_mb   <= mb;
    s1_exp  <= xa + xb + XW'(Bias);
    s1_spec <= spec;
  end

  // stage 2: exact significand product
  logic                 s2_valid, s2_sign;
  logic [ProdW-1:0]     s2_prod;
  logic signed [XW-1:0] s2_exp;
  spec_t                s2_spec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_sign <= s1_sign;
    s2_prod <= ProdW'(s1_ma) * ProdW'(s1_mb);
    s2_exp  <= s1_exp;
    s2_spec <= s1_spec;
  end

  // stages 3 and 4: normalize and round
  fpm_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_sign   (s2_sign),
    .in_exp    (s2_exp),
    .in_prod   (s2_prod),
    .in_spec   (s2_spec),
    .out_valid (done),
    .out_word  (product)
  );

`ifndef SYNTHESIS
  // a request shows up as a done strobe once it has passed every stage
  assert property (@(posedge clk) disable iff (rst)
    start ##1 !rst ##1 !rst ##1 !rst |=> done)
    else $error("request lost in pipe");
  // no rising done strobe without a request that entered the pipe for it
  assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(start, 4))
    else $error("done without request");
  // a special-case outcome travels on into stage two
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_spec.special |=> s2_spec.special)
    else $error("special case dropped");
`endif

endmodule
